FILE: sv/mea_pkg.sv
package mea_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 6;
	localparam int SHAMT_W = 5;
	localparam int IMM_W   = 16;

	typedef logic [DATA_W-1:0] word_t;

	// R-type funct codes
	typedef enum logic [OP_W-1:0] {
		FN_SLL  = 6'h00,
		FN_SRL  = 6'h02,
		FN_SRA  = 6'h03,
		FN_SLLV = 6'h04,
		FN_SRLV = 6'h06,
		FN_SRAV = 6'h07,
		FN_ADD  = 6'h20,
		FN_ADDU = 6'h21,
		FN_SUB  = 6'h22,
		FN_SUBU = 6'h23,
		FN_AND  = 6'h24,
		FN_OR   = 6'h25,
		FN_XOR  = 6'h26,
		FN_SLT  = 6'h2A,
		FN_SLTU = 6'h2B
	} funct_t;

	// I-type opcodes
	typedef enum logic [OP_W-1:0] {
		OP_BEQ   = 6'h04,
		OP_BNE   = 6'h05,
		OP_ADDI  = 6'h08,
		OP_ADDIU = 6'h09,
		OP_SLTI  = 6'h0A,
		OP_SLTIU = 6'h0B,
		OP_ANDI  = 6'h0C,
		OP_ORI   = 6'h0D,
		OP_XORI  = 6'h0E,
		OP_LUI   = 6'h0F,
		OP_LW    = 6'h23,
		OP_SW    = 6'h2B
	} opcode_t;

	// operation class
	localparam logic CMD_R = 1'b0;
	localparam logic CMD_I = 1'b1;

	function automatic word_t sext_imm(input logic [IMM_W-1:0] imm);
		sext_imm = {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
	endfunction

	// pc + (sext(imm) << 2), wrapping
	function automatic word_t branch_tgt(input word_t pc, input logic [IMM_W-1:0] imm);
		word_t off;
		off = sext_imm(imm);
		branch_tgt = pc + {off[DATA_W-3:0], 2'b00};
	endfunction

endpackage

FILE: sv/mips_execute_alu_unit.sv
// A transaction is captured in the input register, and its result and done then show from
// the result register (input reg, result reg).
// Throughput: one transaction per cycle; busy is never raised.
// The receiver cannot stall: each result shows on the result ports for one cycle with done.
// Reset (arst_n low, asynchronous) clears the valid bits of both stages only; no other state.
// Longest path: the 32-bit add/subtract and compare feeding the result mux in stage two.
module mips_execute_alu_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [mea_pkg::OP_W-1:0]      op_code,
	input  logic [mea_pkg::DATA_W-1:0]    rs_value,
	input  logic [mea_pkg::DATA_W-1:0]    rt_value,
	input  logic [mea_pkg::SHAMT_W-1:0]   shift_amount,
	input  logic signed [mea_pkg::IMM_W-1:0] immediate,
	input  logic [mea_pkg::DATA_W-1:0]    pc_value,
	output logic                          done,
	output logic [mea_pkg::DATA_W-1:0]    alu_result,
	output logic                          status_flag,
	output logic [mea_pkg::DATA_W-1:0]    branch_target,
	output logic                          unsupported
);
	import mea_pkg::*;

	// ---------------- stage 1: input register ----------------
	logic                  vld_s1;
	logic                  cmd_s1;
	logic [OP_W-1:0]       op_s1;
	word_t                 rs_s1;
	word_t                 rt_s1;
	logic [SHAMT_W-1:0]    sa_s1;
	logic [IMM_W-1:0]      imm_s1;
	word_t                 pc_s1;

	// no stall anywhere, so the block is always ready
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= cmd;
			op_s1  <= op_code;
			rs_s1  <= rs_value;
			rt_s1  <= rt_value;
			sa_s1  <= shift_amount;
			imm_s1 <= immediate;
			pc_s1  <= pc_value;
		end
	end

	// ---------------- execute logic ----------------
	word_t              simm;
	word_t              zimm;
	word_t              sum_rr;
	word_t              diff_rr;
	word_t              sum_ri;
	logic [SHAMT_W-1:0] var_sh;
	logic               ovf_add;
	logic               ovf_sub;
	logic               ovf_addi;
	word_t              res_d;
	logic               flag_d;
	logic               bad_d;

	assign simm    = sext_imm(imm_s1);
	assign zimm    = {{(DATA_W-IMM_W){1'b0}}, imm_s1};
	assign sum_rr  = rs_s1 + rt_s1;
	assign diff_rr = rs_s1 - rt_s1;
	assign sum_ri  = rs_s1 + simm;
	assign var_sh  = rs_s1[SHAMT_W-1:0];

	// signed overflow: operands agree in sign (add) or differ (sub), result flips
	assign ovf_add  = ~(rs_s1[DATA_W-1] ^ rt_s1[DATA_W-1]) & (rs_s1[DATA_W-1] ^ sum_rr[DATA_W-1]);
	assign ovf_sub  = (rs_s1[DATA_W-1] ^ rt_s1[DATA_W-1]) & (rs_s1[DATA_W-1] ^ diff_rr[DATA_W-1]);
	assign ovf_addi = ~(rs_s1[DATA_W-1] ^ simm[DATA_W-1]) & (rs_s1[DATA_W-1] ^ sum_ri[DATA_W-1]);

	always_comb begin
		res_d  = '0;
		flag_d = 1'b0;
		bad_d  = 1'b0;
		if (cmd_s1 == CMD_R) begin
			unique case (funct_t'(op_s1))
				FN_SLL:  res_d = rt_s1 << sa_s1;
				FN_SRL:  res_d = rt_s1 >> sa_s1;
				FN_SRA:  res_d = word_t'($signed(rt_s1) >>> sa_s1);
				FN_SLLV: res_d = rt_s1 << var_sh;
				FN_SRLV: res_d = rt_s1 >> var_sh;
				FN_SRAV: res_d = word_t'($signed(rt_s1) >>> var_sh);
				FN_ADD: begin
					res_d  = sum_rr;
					flag_d = ovf_add;
				end
				FN_ADDU: res_d = sum_rr;
				FN_SUB: begin
					res_d  = diff_rr;
					flag_d = ovf_sub;
				end
				FN_SUBU: res_d = diff_rr;
				FN_AND:  res_d = rs_s1 & rt_s1;
				FN_OR:   res_d = rs_s1 | rt_s1;
				FN_XOR:  res_d = rs_s1 ^ rt_s1;
				FN_SLT:  res_d = word_t'($signed(rs_s1) < $signed(rt_s1));
				FN_SLTU: res_d = word_t'(rs_s1 < rt_s1);
				default: bad_d = 1'b1;
			endcase
		end else begin
			unique case (opcode_t'(op_s1))
				OP_BEQ: begin
					res_d  = rt_s1;
					flag_d = (rs_s1 == rt_s1);
				end
				OP_BNE: begin
					res_d  = rt_s1;
					flag_d = (rs_s1 != rt_s1);
				end
				OP_ADDI: begin
					res_d  = sum_ri;
					flag_d = ovf_addi;
				end
				OP_ADDIU: res_d = sum_ri;
				OP_SLTI:  res_d = word_t'($signed(rs_s1) < $signed(simm));
				OP_SLTIU: res_d = word_t'(rs_s1 < simm);
				OP_ANDI:  res_d = rs_s1 & zimm;
				OP_ORI:   res_d = rs_s1 | zimm;
				OP_XORI:  res_d = rs_s1 ^ zimm;
				OP_LUI:   res_d = {imm_s1, {(DATA_W-IMM_W){1'b0}}};
				OP_LW:    res_d = sum_ri;
				OP_SW:    res_d = sum_ri;
				default:  bad_d = 1'b1;
			endcase
		end
	end

	// ---------------- stage 2: result register ----------------
	logic  done_s2;
	word_t res_s2;
	logic  flag_s2;
	word_t tgt_s2;
	logic  bad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2  <= res_d;
			flag_s2 <= flag_d;
			tgt_s2  <= branch_tgt(pc_s1, imm_s1);
			bad_s2  <= bad_d;
		end
	end

	assign done          = done_s2;
	assign alu_result    = res_s2;
	assign status_flag   = flag_s2;
	assign branch_target = tgt_s2;
	assign unsupported   = bad_s2;

endmodule

FILE: sv/mea_checker.sv
module mea_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [mea_pkg::IMM_W-1:0]     immediate,
	input logic [mea_pkg::DATA_W-1:0]    pc_value,
	input logic                          done,
	input logic [mea_pkg::DATA_W-1:0]    alu_result,
	input logic                          status_flag,
	input logic [mea_pkg::DATA_W-1:0]    branch_target,
	input logic                          unsupported
);
	import mea_pkg::*;

	word_t exp_tgt;
	assign exp_tgt = branch_tgt(pc_value, immediate);

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted transaction produced no result");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without an accepted transaction");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && unsupported) |-> (alu_result == '0 && !status_flag))
		else $error("unsupported op left a nonzero result or flag");

	a_target: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (branch_target == $past(exp_tgt, 2)))
		else $error("branch target mismatch");

endmodule

bind mips_execute_alu_unit mea_checker u_mea_checker (.*);
